@@ src/sine_tone_generator_macros.svh @@
// Assertion macros shared by the sine tone generator RTL.
`ifndef SINE_TONE_GENERATOR_MACROS_SVH
`define SINE_TONE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/stg_pkg.sv @@
// Shared constants, types and tables for the sine tone generator.
`default_nettype none

package stg_pkg;

    // Datapath sizing
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 32;

    // Quarter-wave table geometry
    localparam int QUARTER_LEN = 1 << TABLE_ADDR_BITS;
    localparam int TBL_DEPTH   = QUARTER_LEN + 1;
    localparam int TBL_AW      = TABLE_ADDR_BITS + 1;
    localparam int MAG_BITS    = SAMPLE_BITS - 1;
    localparam logic [MAG_BITS-1:0] AMP = '1;

    // Table build arithmetic (Q2.30 angles, Q30 sine)
    localparam int FRAC_BITS = 30;
    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = WORD_BITS + 1;
    localparam int ACC_BITS  = WORD_BITS + TABLE_ADDR_BITS;
    localparam int DIV_BITS  = 10;
    localparam int TERM_BITS = 4;
    localparam int MAX_TERMS = 12;
    localparam logic [WORD_BITS-1:0] PIHALF_Q30 = 32'd1686629713;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = '0;

    // Table builder sequencer
    typedef enum logic [3:0] {
        FILL_LOAD,
        FILL_MUL1,
        FILL_MUL2,
        FILL_RECIP,
        FILL_BACK,
        FILL_TERM,
        FILL_DIFF,
        FILL_SCALE,
        FILL_WRITE,
        FILL_DONE
    } fill_state_t;

    // Table write port from the builder
    typedef struct packed {
        logic                en;
        logic [TBL_AW-1:0]   addr;
        logic [MAG_BITS-1:0] data;
    } tbl_wr_t;

    // Taylor divisor (2k)(2k+1) for term k
    function automatic logic [DIV_BITS-1:0] taylor_div(input logic [TERM_BITS-1:0] k);
        logic [DIV_BITS-1:0] d;
        unique case (k)
            4'd1:    d = 10'd6;
            4'd2:    d = 10'd20;
            4'd3:    d = 10'd42;
            4'd4:    d = 10'd72;
            4'd5:    d = 10'd110;
            4'd6:    d = 10'd156;
            4'd7:    d = 10'd210;
            4'd8:    d = 10'd272;
            4'd9:    d = 10'd342;
            4'd10:   d = 10'd420;
            4'd11:   d = 10'd506;
            4'd12:   d = 10'd600;
            default: d = 10'd600;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for term k; the quotient estimate is low by at most one
    function automatic logic [WORD_BITS-1:0] taylor_recip(input logic [TERM_BITS-1:0] k);
        logic [WORD_BITS-1:0] r;
        unique case (k)
            4'd1:    r = 32'd715827882;
            4'd2:    r = 32'd214748364;
            4'd3:    r = 32'd102261126;
            4'd4:    r = 32'd59652323;
            4'd5:    r = 32'd39045157;
            4'd6:    r = 32'd27531841;
            4'd7:    r = 32'd20452225;
            4'd8:    r = 32'd15790320;
            4'd9:    r = 32'd12558383;
            4'd10:   r = 32'd10226112;
            4'd11:   r = 32'd8488077;
            4'd12:   r = 32'd7158278;
            default: r = 32'd7158278;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/stg_channels.sv @@
// Request and tone sample channel interfaces.
`default_nettype none

interface stg_req_if;
    logic valid;
    logic ready;
    logic end_of_buffer;

    modport source (output valid, output end_of_buffer, input ready);
    modport sink (input valid, input end_of_buffer, output ready);
endinterface

interface stg_tone_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [stg_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   buffer_done;

    modport source (output valid, output sample, output buffer_done, input ready);
    modport sink (input valid, input sample, input buffer_done, output ready);
endinterface

`default_nettype wire

@@ src/stg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/stg_table_fill.sv @@
// Quarter-wave sine table builder: Taylor series on one shared multiplier.
`default_nettype none

module stg_table_fill (
    input  wire logic             clk,
    input  wire logic             rst_n,
    output stg_pkg::tbl_wr_t      wr,
    output logic                  done
);

    stg_pkg::fill_state_t                    state_reg, state_next;
    logic [stg_pkg::TBL_AW-1:0]              idx_reg, idx_next;
    logic [stg_pkg::ACC_BITS-1:0]            acc_reg, acc_next;
    logic [stg_pkg::TERM_BITS-1:0]           k_reg, k_next;
    logic [stg_pkg::WORD_BITS-1:0]           t_reg, t_next;
    logic [stg_pkg::SUM_BITS-1:0]            pos_reg, pos_next;
    logic [stg_pkg::SUM_BITS-1:0]            neg_reg, neg_next;
    logic [stg_pkg::WORD_BITS-1:0]           n_reg, n_next;
    logic [stg_pkg::WORD_BITS-1:0]           q_reg, q_next;
    logic [stg_pkg::WORD_BITS-1:0]           sin_reg, sin_next;
    logic [stg_pkg::PROD_BITS-1:0]           prod_reg, prod_next;

    logic [stg_pkg::WORD_BITS-1:0]           x;
    logic [stg_pkg::WORD_BITS-1:0]           mul_a, mul_b;
    logic [stg_pkg::WORD_BITS-1:0]           div_w;
    logic [stg_pkg::WORD_BITS-1:0]           rem;
    logic [stg_pkg::WORD_BITS-1:0]           term;
    logic [stg_pkg::PROD_BITS-stg_pkg::FRAC_BITS-1:0] scaled;
    logic                                    last_entry;

    // Angle of the current entry: floor(PIHALF_Q30 * idx / QUARTER_LEN)
    assign x          = acc_reg[stg_pkg::TABLE_ADDR_BITS +: stg_pkg::WORD_BITS];
    assign div_w      = stg_pkg::WORD_BITS'(stg_pkg::taylor_div(k_reg));
    assign last_entry = (idx_reg == stg_pkg::TBL_AW'(stg_pkg::QUARTER_LEN));
    assign rem        = n_reg - prod_reg[stg_pkg::WORD_BITS-1:0];
    assign term       = (rem >= div_w) ? q_reg + 1'b1 : q_reg;
    assign scaled     = prod_reg[stg_pkg::PROD_BITS-1:stg_pkg::FRAC_BITS];

    // Shared multiplier, product registered every cycle
    assign prod_next = mul_a * mul_b;

    // Sequencer: next state, operand selection and table write
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        sin_next   = sin_reg;
        mul_a      = '0;
        mul_b      = '0;
        wr         = '0;
        done       = 1'b0;

        unique case (state_reg)
            stg_pkg::FILL_LOAD:
            begin
                t_next     = x;
                pos_next   = {1'b0, x};
                neg_next   = '0;
                k_next     = stg_pkg::TERM_BITS'(1);
                state_next = stg_pkg::FILL_MUL1;
            end
            stg_pkg::FILL_MUL1:
            begin
                mul_a      = t_reg;
                mul_b      = x;
                state_next = stg_pkg::FILL_MUL2;
            end
            stg_pkg::FILL_MUL2:
            begin
                mul_a      = prod_reg[stg_pkg::FRAC_BITS +: stg_pkg::WORD_BITS];
                mul_b      = x;
                state_next = stg_pkg::FILL_RECIP;
            end
            stg_pkg::FILL_RECIP:
            begin
                // Quotient estimate by reciprocal multiply
                n_next     = prod_reg[stg_pkg::FRAC_BITS +: stg_pkg::WORD_BITS];
                mul_a      = n_next;
                mul_b      = stg_pkg::taylor_recip(k_reg);
                state_next = stg_pkg::FILL_BACK;
            end
            stg_pkg::FILL_BACK:
            begin
                // Multiply back to get the remainder
                q_next     = prod_reg[stg_pkg::WORD_BITS +: stg_pkg::WORD_BITS];
                mul_a      = q_next;
                mul_b      = div_w;
                state_next = stg_pkg::FILL_TERM;
            end
            stg_pkg::FILL_TERM:
            begin
                // Correct the quotient, then add or subtract the term
                t_next = term;
                if (term != '0)
                begin
                    if (k_reg[0])
                    begin
                        neg_next = neg_reg + stg_pkg::SUM_BITS'(term);
                    end
                    else
                    begin
                        pos_next = pos_reg + stg_pkg::SUM_BITS'(term);
                    end
                end
                if (term == '0 || k_reg == stg_pkg::TERM_BITS'(stg_pkg::MAX_TERMS))
                begin
                    state_next = stg_pkg::FILL_DIFF;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = stg_pkg::FILL_MUL1;
                end
            end
            stg_pkg::FILL_DIFF:
            begin
                sin_next   = (pos_reg > neg_reg) ?
                             stg_pkg::WORD_BITS'(pos_reg - neg_reg) : '0;
                state_next = stg_pkg::FILL_SCALE;
            end
            stg_pkg::FILL_SCALE:
            begin
                mul_a      = sin_reg;
                mul_b      = stg_pkg::WORD_BITS'(stg_pkg::AMP);
                state_next = stg_pkg::FILL_WRITE;
            end
            stg_pkg::FILL_WRITE:
            begin
                // Cap at full scale; the last entry is full scale by definition
                wr.en   = 1'b1;
                wr.addr = idx_reg;
                if (last_entry || scaled > stg_pkg::PROD_BITS'(stg_pkg::AMP))
                begin
                    wr.data = stg_pkg::AMP;
                end
                else
                begin
                    wr.data = stg_pkg::MAG_BITS'(scaled);
                end
                if (last_entry)
                begin
                    state_next = stg_pkg::FILL_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    acc_next   = acc_reg + stg_pkg::ACC_BITS'(stg_pkg::PIHALF_Q30);
                    state_next = stg_pkg::FILL_LOAD;
                end
            end
            stg_pkg::FILL_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = stg_pkg::FILL_DONE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stg_pkg::FILL_LOAD;
            idx_reg   <= '0;
            acc_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            k_reg     <= k_next;
        end
    end

    // Arithmetic working registers
    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        n_reg    <= n_next;
        q_reg    <= q_next;
        sin_reg  <= sin_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

@@ src/sine_tone_generator.sv @@
// The request transfer loads the table read data and the stage-1 registers; the output
// register loads from them, so the sample transfer follows the request transfer.
// Throughput: one sample per cycle while tone.ready is high; the table RAM has one registered read port.
// Reset: phase and phase_step clear to zero, then the quarter-wave table of 1025 entries
// is built into RAM; requests wait for it.
// Configuration writes are taken at any time, including during the table build.
`default_nettype none

`include "sine_tone_generator_macros.svh"

module sine_tone_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    stg_req_if.sink                              req,
    stg_tone_if.source                           tone,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [stg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [stg_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    logic [stg_pkg::STEP_BITS-1:0]        step_reg, step_next;
    logic [stg_pkg::PHASE_BITS-1:0]       phase_reg, phase_next;
    logic [stg_pkg::PHASE_BITS-1:0]       step_ext;
    logic [stg_pkg::REG_IDX_W-1:0]        reg_idx;
    logic                                 cfg_wr;

    logic                                 fill_done;
    stg_pkg::tbl_wr_t                     tbl_wr;

    logic                                 in_accept;
    logic [1:0]                           quad;
    logic [stg_pkg::TABLE_ADDR_BITS-1:0]  idx;
    logic [stg_pkg::TBL_AW-1:0]           rd_addr;
    logic [stg_pkg::MAG_BITS-1:0]         rd_data;

    logic                                 s1_valid_reg, s1_valid_next;
    logic                                 s1_neg_reg, s1_neg_next;
    logic                                 s1_eob_reg, s1_eob_next;
    logic                                 out_load;
    logic [stg_pkg::SAMPLE_BITS-1:0]      mag_ext;
    logic                                 out_valid_reg, out_valid_next;
    logic [stg_pkg::SAMPLE_BITS-1:0]      out_sample_reg, out_sample_next;
    logic                                 out_done_reg, out_done_next;

    // Configuration register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[stg_pkg::CFG_ADDR_W-1:2];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign step_next = (cfg_wr && reg_idx == stg_pkg::REG_PHASE_STEP) ? pwdata : step_reg;
    assign prdata    = (reg_idx == stg_pkg::REG_PHASE_STEP) ? step_reg : '0;

    // Table builder and table RAM
    stg_table_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .done  (fill_done)
    );

    stg_ram #(
        .WIDTH (stg_pkg::MAG_BITS),
        .DEPTH (stg_pkg::TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_wr.en),
        .waddr (tbl_wr.addr),
        .wdata (tbl_wr.data),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Request stage: look up the current phase, then advance it
    assign out_load  = s1_valid_reg && (!out_valid_reg || tone.ready);
    assign req.ready = fill_done && (!s1_valid_reg || out_load);
    assign in_accept = req.valid && req.ready;

    assign quad     = phase_reg[stg_pkg::PHASE_BITS-1 -: 2];
    assign idx      = phase_reg[stg_pkg::PHASE_BITS-3 -: stg_pkg::TABLE_ADDR_BITS];
    assign rd_addr  = quad[0] ? (stg_pkg::TBL_AW'(stg_pkg::QUARTER_LEN) - {1'b0, idx})
                              : {1'b0, idx};
    assign step_ext = stg_pkg::PHASE_BITS'(step_reg);

    always_comb
    begin
        phase_next    = in_accept ? phase_reg + step_ext : phase_reg;
        s1_valid_next = in_accept || (s1_valid_reg && !out_load);
        s1_neg_next   = in_accept ? quad[1] : s1_neg_reg;
        s1_eob_next   = in_accept ? req.end_of_buffer : s1_eob_reg;
    end

    // Output stage: apply the sign and load the output register
    assign mag_ext = {1'b0, rd_data};

    always_comb
    begin
        out_valid_next  = out_load || (out_valid_reg && !tone.ready);
        out_sample_next = out_sample_reg;
        out_done_next   = out_done_reg;
        if (out_load)
        begin
            out_sample_next = s1_neg_reg ? -mag_ext : mag_ext;
            out_done_next   = s1_eob_reg;
        end
    end

    assign tone.valid       = out_valid_reg;
    assign tone.sample      = out_sample_reg;
    assign tone.buffer_done = out_done_reg;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_neg_reg     <= s1_neg_next;
        s1_eob_reg     <= s1_eob_next;
        out_sample_reg <= out_sample_next;
        out_done_reg   <= out_done_next;
    end

    // Checks
    `STG_ASSERT_NOW(a_accept_after_fill, in_accept, fill_done, "request taken before table built")
    `STG_ASSERT_NOW(a_no_write_after_fill, fill_done, !tbl_wr.en, "table written after build")
    `STG_ASSERT_NEXT(a_stall_keeps_word, s1_valid_reg && !out_load,
                     s1_valid_reg && $stable(rd_data), "table word lost during stall")
    `STG_ASSERT_NOW(a_sample_in_range, tone.valid,
                    tone.sample != {1'b1, {(stg_pkg::SAMPLE_BITS-1){1'b0}}},
                    "sample at negative full scale")

endmodule

`default_nettype wire
